// ===== rtl/crvp_pkg.sv =====
// Shared types, character codes and helper functions for the Content-Range
// value parser. No dependencies; rtl/ files other than crvp_if.sv use it.
package crvp_pkg;

   // Character codes used by the grammar.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Length of the unit name "bytes".
   localparam logic [2:0] UNIT_LEN = 3'd5;

   // Largest accumulator value that still takes one more digit without
   // overflow: one limit for digits 0 to 5, one for digits 6 to 9.
   localparam logic [63:0] DIGIT_LIMIT_LO = 64'd1844674407370955161;
   localparam logic [63:0] DIGIT_LIMIT_HI = 64'd1844674407370955160;
   localparam logic [3:0]  DIGIT_SPLIT    = 4'd5;

   // Result of one accumulator step.
   typedef struct packed {
      logic [63:0] sum;
      logic        fits;
   } digit_type;

   // One result word.
   typedef struct packed {
      logic        ok;
      logic        has_range;
      logic        has_complete;
      logic [63:0] first_pos;
      logic [63:0] last_pos;
      logic [63:0] complete_len;
   } result_type;

   // Letter of the unit name at a given position.
   function automatic logic [7:0] unit_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h62;   // b
         3'd1:    c = 8'h79;   // y
         3'd2:    c = 8'h74;   // t
         3'd3:    c = 8'h65;   // e
         3'd4:    c = 8'h73;   // s
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ===== rtl/crvp_if.sv =====
// Valid/ready channel interfaces for the Content-Range value parser.
// Depends on nothing but the port widths of the block's fields.

// Request channel: one header byte per word.
interface crvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       final_byte;

   modport source (output valid, output ch, output final_byte, input ready);
   modport sink   (input valid, input ch, input final_byte, output ready);
endinterface

// Response channel: one parse result per word.
interface crvp_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic        has_range;
   logic        has_complete;
   logic [63:0] first_pos;
   logic [63:0] last_pos;
   logic [63:0] complete_len;

   modport source (output valid, output ok, output has_range, output has_complete,
                   output first_pos, output last_pos, output complete_len,
                   input ready);
   modport sink   (input valid, input ok, input has_range, input has_complete,
                   input first_pos, input last_pos, input complete_len,
                   output ready);
endinterface

// ===== rtl/content_range_value_parser_core.sv =====
// Content-Range header value parser, top level.
// Depends on crvp_pkg, crvp_if.sv (crvp_req_if, crvp_rsp_if) and crvp_parser.
//
// The request channel carries the bytes of one header value, one byte per
// word, in order; final_byte marks the last byte of the value. For every
// value the response channel returns exactly one word: ok, the range and
// length flags, and first_pos, last_pos and complete_len (zero where not
// recorded). Bytes that are not final produce no response word.
// A byte taken into the input register is parsed from there; the response
// word for a final byte is registered in the response register when that
// byte leaves the input register.
// The parser takes one byte per cycle while no final byte is held back, set
// by the single pass of the state update between the input register and the
// state and result registers.
// When the receiver stalls with a response word pending, the parser keeps
// consuming bytes that are not final; a final byte waits in the input
// register, with req ready held low, until the pending response word is taken.
// Synchronous reset empties both registers and returns the parser to the
// leading-blank phase with all fields cleared.
module content_range_value_parser_core (
   input  logic       clock,
   input  logic       reset,
   crvp_req_if.sink   req_chan,
   crvp_rsp_if.source rsp_chan
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_ch_ff;
   logic                 in_final_ff;
   logic                 out_valid_ff, out_valid_in;
   crvp_pkg::result_type out_ff;
   crvp_pkg::result_type parse_res;
   logic                 advance;
   logic                 req_take;

   // The held byte moves on unless it is final and the response slot is full.
   assign advance  = in_valid_ff &&
                     (!in_final_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   crvp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .ch         (in_ch_ff),
      .final_byte (in_final_ff),
      .result     (parse_res)
   );

   // Valid bits of the input and response registers.
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && in_final_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff    <= req_chan.ch;
         in_final_ff <= req_chan.final_byte;
      end
      if (advance && in_final_ff) begin
         out_ff <= parse_res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.ok           = out_ff.ok;
   assign rsp_chan.has_range    = out_ff.has_range;
   assign rsp_chan.has_complete = out_ff.has_complete;
   assign rsp_chan.first_pos    = out_ff.first_pos;
   assign rsp_chan.last_pos     = out_ff.last_pos;
   assign rsp_chan.complete_len = out_ff.complete_len;

endmodule

// ===== rtl/crvp_digit.sv =====
// Decimal accumulator step: accum * 10 + digit with an overflow check.
// Depends on crvp_pkg.
module crvp_digit (
   input  logic [63:0]          accum,
   input  logic [3:0]           digit,
   output crvp_pkg::digit_type  result
);

   logic [63:0] limit;

   // The multiply by ten is two shifted copies added together.
   always_comb begin
      limit = (digit > crvp_pkg::DIGIT_SPLIT) ? crvp_pkg::DIGIT_LIMIT_HI
                                              : crvp_pkg::DIGIT_LIMIT_LO;
      result.fits = (accum <= limit);
      result.sum  = (accum << 3) + (accum << 1) + {60'd0, digit};
   end

endmodule

// ===== rtl/crvp_parser.sv =====
// Parser state machine: takes one header byte per step and produces the
// result fields on the final byte. Depends on crvp_pkg and crvp_digit.
module crvp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           ch,
   input  logic                 final_byte,
   output crvp_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_LEAD, PH_PREFIX, PH_GAP1, PH_GAP, PH_USTAR, PH_UCOMP, PH_FIRST,
      PH_LAST, PH_RSEL, PH_RSTAR, PH_RCOMP, PH_TRAIL, PH_ERR
   } phase_type;

   localparam int RANGE_BIT = 0;
   localparam int COMP_BIT  = 1;

   phase_type   phase_ff, phase_in;
   logic [2:0]  prefix_pos_ff, prefix_pos_in;
   logic [63:0] accum_ff, accum_in;
   logic        seen_digit_ff, seen_digit_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] last_ff, last_in;
   logic [63:0] complete_ff, complete_in;
   logic [1:0]  flags_ff, flags_in;

   logic        ch_blank;
   logic        ch_digit;
   logic [3:0]  digit_val;
   logic        ok;
   logic [63:0] complete_out;
   logic [1:0]  flags_out;
   crvp_pkg::digit_type digit_res;

   assign ch_blank  = crvp_pkg::is_blank(ch);
   assign ch_digit  = crvp_pkg::is_digit(ch);
   assign digit_val = ch[3:0];

   crvp_digit u_digit (
      .accum  (accum_ff),
      .digit  (digit_val),
      .result (digit_res)
   );

   // Next parser state for the current byte.
   always_comb begin
      phase_in      = phase_ff;
      prefix_pos_in = prefix_pos_ff;
      accum_in      = accum_ff;
      seen_digit_in = seen_digit_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      complete_in   = complete_ff;
      flags_in      = flags_ff;

      unique case (phase_ff)
         PH_LEAD: begin
            if (!ch_blank) begin
               if (ch == crvp_pkg::unit_char(3'd0)) begin
                  prefix_pos_in = 3'd1;
                  phase_in      = PH_PREFIX;
               end else begin
                  phase_in = PH_ERR;
               end
            end
         end
         PH_PREFIX: begin
            if (prefix_pos_ff < crvp_pkg::UNIT_LEN &&
                ch == crvp_pkg::unit_char(prefix_pos_ff)) begin
               prefix_pos_in = prefix_pos_ff + 3'd1;
               if (prefix_pos_in == crvp_pkg::UNIT_LEN) begin
                  phase_in = PH_GAP1;
               end
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_GAP1: begin
            phase_in = ch_blank ? PH_GAP : PH_ERR;
         end
         PH_GAP: begin
            if (!ch_blank) begin
               if (ch == crvp_pkg::CHAR_STAR) begin
                  phase_in = PH_USTAR;
               end else if (ch_digit) begin
                  accum_in      = {60'd0, digit_val};
                  seen_digit_in = 1'b1;
                  phase_in      = PH_FIRST;
               end else begin
                  phase_in = PH_ERR;
               end
            end
         end
         PH_USTAR: begin
            if (ch == crvp_pkg::CHAR_SLASH) begin
               accum_in      = '0;
               seen_digit_in = 1'b0;
               phase_in      = PH_UCOMP;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_UCOMP: begin
            if (ch_digit) begin
               if (digit_res.fits) begin
                  accum_in      = digit_res.sum;
                  seen_digit_in = 1'b1;
               end else begin
                  phase_in = PH_ERR;
               end
            end else if (!seen_digit_ff) begin
               phase_in = PH_ERR;
            end else begin
               complete_in        = accum_ff;
               flags_in[COMP_BIT] = 1'b1;
               phase_in           = ch_blank ? PH_TRAIL : PH_ERR;
            end
         end
         PH_FIRST: begin
            if (ch_digit) begin
               if (digit_res.fits) begin
                  accum_in      = digit_res.sum;
                  seen_digit_in = 1'b1;
               end else begin
                  phase_in = PH_ERR;
               end
            end else if (ch == crvp_pkg::CHAR_DASH) begin
               first_in      = accum_ff;
               accum_in      = '0;
               seen_digit_in = 1'b0;
               phase_in      = PH_LAST;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_LAST: begin
            if (ch_digit) begin
               if (digit_res.fits) begin
                  accum_in      = digit_res.sum;
                  seen_digit_in = 1'b1;
               end else begin
                  phase_in = PH_ERR;
               end
            end else if (!seen_digit_ff || accum_ff < first_ff ||
                         ch != crvp_pkg::CHAR_SLASH) begin
               phase_in = PH_ERR;
            end else begin
               last_in             = accum_ff;
               flags_in[RANGE_BIT] = 1'b1;
               phase_in            = PH_RSEL;
            end
         end
         PH_RSEL: begin
            if (ch == crvp_pkg::CHAR_STAR) begin
               phase_in = PH_RSTAR;
            end else if (ch_digit) begin
               accum_in      = {60'd0, digit_val};
               seen_digit_in = 1'b1;
               phase_in      = PH_RCOMP;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_RSTAR, PH_TRAIL: begin
            phase_in = ch_blank ? PH_TRAIL : PH_ERR;
         end
         PH_RCOMP: begin
            if (ch_digit) begin
               if (digit_res.fits) begin
                  accum_in      = digit_res.sum;
                  seen_digit_in = 1'b1;
               end else begin
                  phase_in = PH_ERR;
               end
            end else if (last_ff >= accum_ff) begin
               phase_in = PH_ERR;
            end else begin
               complete_in        = accum_ff;
               flags_in[COMP_BIT] = 1'b1;
               phase_in           = ch_blank ? PH_TRAIL : PH_ERR;
            end
         end
         PH_ERR: begin
            phase_in = PH_ERR;
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   // Closing checks on the final byte, applied to the state after the byte.
   always_comb begin
      ok           = 1'b0;
      complete_out = complete_in;
      flags_out    = flags_in;
      case (phase_in)
         PH_UCOMP: begin
            if (seen_digit_in) begin
               complete_out        = accum_in;
               flags_out[COMP_BIT] = 1'b1;
               ok                  = 1'b1;
            end
         end
         PH_RCOMP: begin
            if (last_in < accum_in) begin
               complete_out        = accum_in;
               flags_out[COMP_BIT] = 1'b1;
               ok                  = 1'b1;
            end
         end
         PH_RSTAR, PH_TRAIL: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      result.ok           = ok;
      result.has_range    = flags_out[RANGE_BIT];
      result.has_complete = flags_out[COMP_BIT];
      result.first_pos    = flags_out[RANGE_BIT] ? first_in : '0;
      result.last_pos     = flags_out[RANGE_BIT] ? last_in : '0;
      result.complete_len = flags_out[COMP_BIT] ? complete_out : '0;
   end

   // Parser state; the final byte returns everything to the reset values.
   always_ff @(posedge clock) begin
      if (reset || (step_en && final_byte)) begin
         phase_ff      <= PH_LEAD;
         prefix_pos_ff <= '0;
         accum_ff      <= '0;
         seen_digit_ff <= 1'b0;
         first_ff      <= '0;
         last_ff       <= '0;
         complete_ff   <= '0;
         flags_ff      <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         prefix_pos_ff <= prefix_pos_in;
         accum_ff      <= accum_in;
         seen_digit_ff <= seen_digit_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         complete_ff   <= complete_in;
         flags_ff      <= flags_in;
      end
   end

endmodule
